// File: rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants for the bearing-to-target pipeline
// Holds the arctangent table, the fixed angle formats and the sideband flags
// that ride along with each beat.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

  // Guard bits added below the integer offset in the CORDIC datapath
  localparam int GUARD_BITS = 16;
  // Number of entries in the arctangent table
  localparam int ATAN_ENTRIES = 24;
  // Angle accumulator width: 2^32 units per turn
  localparam int ACC_BITS = 32;

  localparam logic [ACC_BITS-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ACC_BITS-1:0] QUARTER_TURN = 32'h4000_0000;

  // Flags that travel with a beat through the pipeline
  typedef struct packed {
    logic left;       // rotated y at or above zero
    logic at_target;  // offset is exactly zero
  } side_t;

  // round(atan(2^-i) * 2^32 / 2pi)
  function automatic logic [ACC_BITS-1:0] atan_lut(input int idx);
    logic [ACC_BITS-1:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/signed_bearing_to_target.sv
// ----------------------------------------------------------------------------
// signed_bearing_to_target: signed turn angle from robot heading to a target
// Rotates the target offset by minus the heading, then measures its angle
// with a second CORDIC, both fully unrolled into one pipeline.
// ----------------------------------------------------------------------------
// One query enters per clock; the result passes through two setup stages,
// one register per rotation step, one vectoring setup stage, one register
// per vectoring step and the output register. The whole pipeline advances
// together; it stalls only when the output beat is held and the last stage
// is occupied, and a bubble in the last stage is squeezed out even while the
// output waits.
// turn_angle is in 2^ANGLE_BITS units per turn, positive to the left, and a
// target straight behind reads as +2^(ANGLE_BITS-1). A target on top of the
// robot gives angle 0 with the at_target flag set in tuser.
`default_nettype none

module signed_bearing_to_target #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 20,
  parameter int ANGLE_BITS    = 16
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  // robot_x, robot_y, robot_heading, goal_x, goal_y (low bits first)
  input  wire logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  input  wire logic                                           s_axis_tvalid_i,
  output logic                                                s_axis_tready_o,
  // turn_angle (low bits first)
  output logic [((ANGLE_BITS+1+7)/8)*8-1:0]                   m_axis_tdata_o,
  // at_target
  output logic                                                m_axis_tuser_o,
  output logic                                                m_axis_tvalid_o,
  input  wire logic                                           m_axis_tready_i
);

  localparam int AB      = sbt_pkg::ACC_BITS;
  localparam int DW      = COORD_BITS + sbt_pkg::GUARD_BITS + 4;
  localparam int OUT_W   = ((ANGLE_BITS + 1 + 7) / 8) * 8;
  localparam int N       = CORDIC_STAGES;
  localparam int OFS_RY  = COORD_BITS;
  localparam int OFS_H   = 2 * COORD_BITS;
  localparam int OFS_GX  = 2 * COORD_BITS + ANGLE_BITS;
  localparam int OFS_GY  = 3 * COORD_BITS + ANGLE_BITS;

  logic adv;

  // Input field unpacking
  logic signed [COORD_BITS-1:0] robot_x, robot_y, goal_x, goal_y;
  logic        [ANGLE_BITS-1:0] robot_heading;

  assign robot_x       = signed'(s_axis_tdata_i[COORD_BITS-1:0]);
  assign robot_y       = signed'(s_axis_tdata_i[OFS_RY +: COORD_BITS]);
  assign robot_heading = s_axis_tdata_i[OFS_H +: ANGLE_BITS];
  assign goal_x        = signed'(s_axis_tdata_i[OFS_GX +: COORD_BITS]);
  assign goal_y        = signed'(s_axis_tdata_i[OFS_GY +: COORD_BITS]);

  assign s_axis_tready_o = adv;

  // Rotation chain: index 0 is the setup output
  logic                 rv [N+1];
  logic signed [DW-1:0] rx [N+1];
  logic signed [DW-1:0] ry [N+1];
  logic [AB-1:0]        rz [N+1];
  sbt_pkg::side_t       rs [N+1];

  sbt_prep #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .DW         (DW)
  ) u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ce_i            (adv),
    .valid_i         (s_axis_tvalid_i),
    .robot_x_i       (robot_x),
    .robot_y_i       (robot_y),
    .robot_heading_i (robot_heading),
    .goal_x_i        (goal_x),
    .goal_y_i        (goal_y),
    .valid_o         (rv[0]),
    .x_o             (rx[0]),
    .y_o             (ry[0]),
    .z_o             (rz[0]),
    .side_o          (rs[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_rot
    sbt_cordic_stage #(
      .DW     (DW),
      .SHIFT  (i),
      .VECTOR (1'b0)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (adv),
      .valid_i (rv[i]),
      .x_i     (rx[i]),
      .y_i     (ry[i]),
      .z_i     (rz[i]),
      .side_i  (rs[i]),
      .valid_o (rv[i+1]),
      .x_o     (rx[i+1]),
      .y_o     (ry[i+1]),
      .z_o     (rz[i+1]),
      .side_o  (rs[i+1])
    );
  end

  // Vectoring setup: record the side, fold into the right half plane
  logic                 vv [N+1];
  logic signed [DW-1:0] vx [N+1];
  logic signed [DW-1:0] vy [N+1];
  logic [AB-1:0]        vz [N+1];
  sbt_pkg::side_t       vs [N+1];

  logic                 vp_valid_q;
  logic signed [DW-1:0] vp_x_q, vp_x_d;
  logic signed [DW-1:0] vp_y_q, vp_y_d;
  logic [AB-1:0]        vp_acc_q, vp_acc_d;
  sbt_pkg::side_t       vp_side_q, vp_side_d;

  always_comb begin
    vp_side_d.at_target = rs[N].at_target;
    vp_side_d.left      = ~ry[N][DW-1];
    if (rx[N][DW-1]) begin
      vp_x_d   = -rx[N];
      vp_y_d   = -ry[N];
      vp_acc_d = sbt_pkg::HALF_TURN;
    end else begin
      vp_x_d   = rx[N];
      vp_y_d   = ry[N];
      vp_acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_valid_q <= 1'b0;
    end else if (adv) begin
      vp_valid_q <= rv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vp_x_q    <= vp_x_d;
      vp_y_q    <= vp_y_d;
      vp_acc_q  <= vp_acc_d;
      vp_side_q <= vp_side_d;
    end
  end

  assign vv[0] = vp_valid_q;
  assign vx[0] = vp_x_q;
  assign vy[0] = vp_y_q;
  assign vz[0] = vp_acc_q;
  assign vs[0] = vp_side_q;

  for (genvar i = 0; i < N; i++) begin : g_vec
    sbt_cordic_stage #(
      .DW     (DW),
      .SHIFT  (i),
      .VECTOR (1'b1)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (adv),
      .valid_i (vv[i]),
      .x_i     (vx[i]),
      .y_i     (vy[i]),
      .z_i     (vz[i]),
      .side_i  (vs[i]),
      .valid_o (vv[i+1]),
      .x_o     (vx[i+1]),
      .y_o     (vy[i+1]),
      .z_o     (vz[i+1]),
      .side_o  (vs[i+1])
    );
  end

  // Rounding and output beat
  logic signed [ANGLE_BITS:0] turn_angle;

  sbt_finish #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (vv[N]),
    .acc_i        (vz[N]),
    .side_i       (vs[N]),
    .ready_i      (m_axis_tready_i),
    .adv_o        (adv),
    .valid_o      (m_axis_tvalid_o),
    .turn_angle_o (turn_angle),
    .at_target_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_W'(unsigned'(turn_angle));

  // Checks
  localparam logic [ANGLE_BITS:0] NEG_HALF = {2'b11, {(ANGLE_BITS-1){1'b0}}};

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> turn_angle == '0)
    else $error("at_target beat with nonzero angle");

  a_no_neg_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> unsigned'(turn_angle) != NEG_HALF)
    else $error("behind target reported as minus half turn");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i && vv[N])
    else $error("input stalled without a held output beat");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

endmodule

`default_nettype wire

// File: rtl/sbt_prep.sv
// ----------------------------------------------------------------------------
// sbt_prep: offset and quadrant setup
// Stage one forms the target offset and the negated heading. Stage two scales
// the offset into the datapath, flags a zero offset and folds the rotation
// angle into the right half plane.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_prep #(
  parameter int COORD_BITS = 20,
  parameter int ANGLE_BITS = 16,
  parameter int DW         = 40
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                ce_i,
  input  wire logic                                valid_i,
  input  wire logic signed [COORD_BITS-1:0]        robot_x_i,
  input  wire logic signed [COORD_BITS-1:0]        robot_y_i,
  input  wire logic        [ANGLE_BITS-1:0]        robot_heading_i,
  input  wire logic signed [COORD_BITS-1:0]        goal_x_i,
  input  wire logic signed [COORD_BITS-1:0]        goal_y_i,
  output logic                                     valid_o,
  output logic signed [DW-1:0]                     x_o,
  output logic signed [DW-1:0]                     y_o,
  output logic [sbt_pkg::ACC_BITS-1:0]             z_o,
  output sbt_pkg::side_t                           side_o
);

  localparam int GB  = sbt_pkg::GUARD_BITS;
  localparam int AB  = sbt_pkg::ACC_BITS;
  localparam int EXT = DW - COORD_BITS - 1 - GB;

  // Stage one: offset and negated heading
  logic                         v1_q;
  logic signed [COORD_BITS:0]   dx_q, dx_d;
  logic signed [COORD_BITS:0]   dy_q, dy_d;
  logic [AB-1:0]                z1_q, z1_d;

  assign dx_d = {goal_x_i[COORD_BITS-1], goal_x_i} - {robot_x_i[COORD_BITS-1], robot_x_i};
  assign dy_d = {goal_y_i[COORD_BITS-1], goal_y_i} - {robot_y_i[COORD_BITS-1], robot_y_i};
  assign z1_d = AB'(0) - {robot_heading_i, {(AB-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ce_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      z1_q <= z1_d;
    end
  end

  // Stage two: scale, zero check, half-turn fold
  logic                 v2_q;
  logic signed [DW-1:0] xs, ys;
  logic signed [DW-1:0] x2_q, x2_d;
  logic signed [DW-1:0] y2_q, y2_d;
  logic [AB-1:0]        zq_sum;
  logic [AB-1:0]        z2_q, z2_d;
  sbt_pkg::side_t       side2_q, side2_d;

  always_comb begin
    xs     = {{EXT{dx_q[COORD_BITS]}}, dx_q, {GB{1'b0}}};
    ys     = {{EXT{dy_q[COORD_BITS]}}, dy_q, {GB{1'b0}}};
    zq_sum = z1_q + sbt_pkg::QUARTER_TURN;
    // z at or past plus a quarter turn, or past minus a quarter turn: rotate by half a turn up front
    if (zq_sum[AB-1]) begin
      x2_d = -xs;
      y2_d = -ys;
      z2_d = z1_q + sbt_pkg::HALF_TURN;
    end else begin
      x2_d = xs;
      y2_d = ys;
      z2_d = z1_q;
    end
    side2_d.left      = 1'b0;
    side2_d.at_target = (dx_q == '0) && (dy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ce_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x2_q    <= x2_d;
      y2_q    <= y2_d;
      z2_q    <= z2_d;
      side2_q <= side2_d;
    end
  end

  assign valid_o = v2_q;
  assign x_o     = x2_q;
  assign y_o     = y2_q;
  assign z_o     = z2_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

// File: rtl/sbt_cordic_stage.sv
// ----------------------------------------------------------------------------
// sbt_cordic_stage: one registered CORDIC micro-rotation
// Rotation mode steers by the sign of the angle, vectoring mode by the sign
// of y. A counterclockwise step always subtracts the table angle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_cordic_stage #(
  parameter int DW     = 40,
  parameter int SHIFT  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         ce_i,
  input  wire logic                         valid_i,
  input  wire logic signed [DW-1:0]         x_i,
  input  wire logic signed [DW-1:0]         y_i,
  input  wire logic [sbt_pkg::ACC_BITS-1:0] z_i,
  input  wire sbt_pkg::side_t               side_i,
  output logic                              valid_o,
  output logic signed [DW-1:0]              x_o,
  output logic signed [DW-1:0]              y_o,
  output logic [sbt_pkg::ACC_BITS-1:0]      z_o,
  output sbt_pkg::side_t                    side_o
);

  localparam int AB = sbt_pkg::ACC_BITS;
  localparam logic [AB-1:0] ATAN = sbt_pkg::atan_lut(SHIFT);

  logic                 valid_q;
  logic signed [DW-1:0] x_q, x_d;
  logic signed [DW-1:0] y_q, y_d;
  logic [AB-1:0]        z_q, z_d;
  sbt_pkg::side_t       side_q;
  logic signed [DW-1:0] xsh, ysh;
  logic                 ccw;

  // Floor shifts, then add or subtract by direction
  always_comb begin
    xsh = x_i >>> SHIFT;
    ysh = y_i >>> SHIFT;
    ccw = VECTOR ? y_i[DW-1] : ~z_i[AB-1];
    if (ccw) begin
      x_d = x_i - ysh;
      y_d = y_i + xsh;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ysh;
      y_d = y_i - xsh;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// File: rtl/sbt_finish.sv
// ----------------------------------------------------------------------------
// sbt_finish: angle rounding, sign and output register
// Rounds the 32-bit angle to the output resolution, folds it to a signed
// bearing and holds the result beat until the sink takes it. Also produces
// the shared pipeline advance.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_finish #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [sbt_pkg::ACC_BITS-1:0] acc_i,
  input  wire sbt_pkg::side_t               side_i,
  input  wire logic                         ready_i,
  output logic                              adv_o,
  output logic                              valid_o,
  output logic signed [ANGLE_BITS:0]        turn_angle_o,
  output logic                              at_target_o
);

  localparam int AB = sbt_pkg::ACC_BITS;
  localparam logic [AB-1:0]         RND  = AB'(1) << (AB - 1 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  logic                     out_valid_q;
  logic signed [ANGLE_BITS:0] angle_q, angle_d;
  logic                     at_q;
  logic [AB-1:0]            acc_rnd;
  logic [ANGLE_BITS-1:0]    v;
  logic [ANGLE_BITS-1:0]    mag;
  logic                     load;

  // Round half up, then fold to magnitude and apply the side
  always_comb begin
    acc_rnd = acc_i + RND;
    v       = acc_rnd[AB-1 -: ANGLE_BITS];
    mag     = v[ANGLE_BITS-1] ? (ANGLE_BITS'(0) - v) : v;
    if (side_i.at_target) begin
      angle_d = '0;
    end else if (v == HALF) begin
      // exactly behind reads as plus half a turn
      angle_d = signed'({1'b0, HALF});
    end else if (side_i.left) begin
      angle_d = signed'({1'b0, mag});
    end else begin
      angle_d = -signed'({1'b0, mag});
    end
  end

  // Output slot is free, drained, or the last stage holds a bubble
  assign load  = ready_i || !out_valid_q;
  assign adv_o = load || !valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      angle_q <= angle_d;
      at_q    <= side_i.at_target;
    end
  end

  assign valid_o      = out_valid_q;
  assign turn_angle_o = angle_q;
  assign at_target_o  = at_q;

endmodule

`default_nettype wire
